// ===== design/aae_pkg.sv =====
// ----------------------------------------------------------------------------
// aae_pkg
// Shared types, character constants and the escape-sequence character lookup
// for the color attribute to ANSI escape expander.
// ----------------------------------------------------------------------------
package aae_pkg;

    localparam logic [7:0] ESC_CHAR   = 8'h1B;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;  // '['
    localparam logic [7:0] CH_SEMI    = 8'h3B;  // ';'
    localparam logic [7:0] CH_M       = 8'h6D;  // 'm'
    localparam logic [7:0] CH_DIGIT0  = 8'h30;  // '0'
    localparam logic [7:0] CH_DIGIT1  = 8'h31;  // '1'
    localparam logic [7:0] CH_DIGIT3  = 8'h33;  // '3'
    localparam logic [7:0] CH_DIGIT4  = 8'h34;  // '4'
    localparam logic [7:0] CH_DIGIT9  = 8'h39;  // '9'

    // position within an expanded sequence (at most 11 characters)
    localparam int unsigned SEQ_IDX_W = 4;

    localparam logic [SEQ_IDX_W-1:0] IDX_ESC    = 4'd0;
    localparam logic [SEQ_IDX_W-1:0] IDX_LBRACK = 4'd1;
    localparam logic [SEQ_IDX_W-1:0] IDX_RESET  = 4'd2;
    localparam logic [SEQ_IDX_W-1:0] IDX_SEMI1  = 4'd3;
    localparam logic [SEQ_IDX_W-1:0] IDX_FG_HI  = 4'd4;
    localparam logic [SEQ_IDX_W-1:0] IDX_FG_LO  = 4'd5;
    localparam logic [SEQ_IDX_W-1:0] IDX_SEMI2  = 4'd6;
    localparam logic [SEQ_IDX_W-1:0] IDX_BG_0   = 4'd7;
    localparam logic [SEQ_IDX_W-1:0] IDX_BG_1   = 4'd8;
    localparam logic [SEQ_IDX_W-1:0] IDX_BG_2   = 4'd9;
    localparam logic [SEQ_IDX_W-1:0] IDX_BG_3   = 4'd10;

    // one unit of work handed from the decoder to the emitter
    typedef struct packed {
        logic       vld;   // a job is produced this cycle
        logic       seq;   // expand data as a color attribute
        logic [7:0] data;  // plain byte or attribute
    } t_job;

    // character and last flag of one position of the attribute expansion
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_seq_char;

    // ones digit of both color codes: the low three bits reversed
    function automatic logic [7:0] color_ones(input logic [3:0] nib);
        return CH_DIGIT0 + {5'd0, nib[0], nib[1], nib[2]};
    endfunction

    function automatic t_seq_char seq_char(input logic [7:0] attr,
                                           input logic [SEQ_IDX_W-1:0] idx);
        logic [3:0] fg;
        logic [3:0] bg;
        logic       fg_bright;
        logic       bg_bright;
        logic [7:0] fg_tens;
        logic [7:0] bg_tens;
        t_seq_char  r;
        fg        = attr[3:0];
        bg        = attr[7:4];
        // foreground yellow and white, and background white, stay in the normal range
        fg_bright = fg[3] && (fg[2:1] != 2'b11);
        bg_bright = bg[3] && (bg != 4'hF);
        fg_tens   = fg_bright ? CH_DIGIT9 : CH_DIGIT3;
        bg_tens   = bg_bright ? CH_DIGIT0 : CH_DIGIT4;
        r.last    = 1'b0;
        unique case (idx)
            IDX_ESC:    r.ch = ESC_CHAR;
            IDX_LBRACK: r.ch = CH_LBRACK;
            IDX_RESET:  r.ch = CH_DIGIT0;
            IDX_SEMI1:  r.ch = CH_SEMI;
            IDX_FG_HI:  r.ch = fg_tens;
            IDX_FG_LO:  r.ch = color_ones(fg);
            IDX_SEMI2:  r.ch = CH_SEMI;
            IDX_BG_0:   r.ch = bg_bright ? CH_DIGIT1 : bg_tens;
            IDX_BG_1:   r.ch = bg_bright ? bg_tens : color_ones(bg);
            IDX_BG_2: begin
                r.ch   = bg_bright ? color_ones(bg) : CH_M;
                r.last = !bg_bright;
            end
            IDX_BG_3: begin
                r.ch   = CH_M;
                r.last = 1'b1;
            end
            default: begin
                r.ch   = CH_M;
                r.last = 1'b1;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== design/aae_if.sv =====
// ----------------------------------------------------------------------------
// aae_in_if / aae_out_if
// Valid/ready stream channels for console bytes in and serial characters out.
// ----------------------------------------------------------------------------
interface aae_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       first_of_call;

    modport source (output valid, output byte_in, output first_of_call, input ready);
    modport sink   (input valid, input byte_in, input first_of_call, output ready);
endinterface

interface aae_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       last_of_run;

    modport source (output valid, output char_out, output last_of_run, input ready);
    modport sink   (input valid, input char_out, input last_of_run, output ready);
endinterface

// ===== design/color_attribute_to_ansi_escape_core.sv =====
// ----------------------------------------------------------------------------
// color_attribute_to_ansi_escape_core
// Console byte stream filter that expands escape-prefixed color attributes
// into ANSI SGR sequences.
//
//   channel | dir | payload                        | transaction
//   --------+-----+--------------------------------+-----------------------
//   i_in    | in  | byte_in[7:0], first_of_call    | valid && ready
//   o_out   | out | char_out[7:0], last_of_run     | valid && ready
//
// A plain byte goes via the job register to the output register; bytes
// stream at one per cycle when not stalled. An attribute gives 10 or 11
// characters from the job register at that rate; input waits for the last.
// Escape, zero and halted bytes produce nothing and wait only on job_ready.
// Synchronous active-low reset clears call state, job and output valid.
// A stalled output holds its character; the job register waits behind it.
// ----------------------------------------------------------------------------
module color_attribute_to_ansi_escape_core
    import aae_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    aae_in_if.sink     i_in,
    aae_out_if.source  o_out
);

    logic in_accept;
    logic job_ready;
    t_job job;

    assign i_in.ready = job_ready;
    assign in_accept  = i_in.valid && job_ready;

    // call state and byte classification
    aae_dec u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_in.byte_in),
        .i_first  (i_in.first_of_call),
        .o_job    (job)
    );

    // character emission
    aae_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_out_ready (o_out.ready),
        .o_job_ready (job_ready),
        .o_out_valid (o_out.valid),
        .o_out_char  (o_out.char_out),
        .o_out_last  (o_out.last_of_run)
    );

endmodule

// ===== design/aae_dec.sv =====
// ----------------------------------------------------------------------------
// aae_dec
// Call state tracking: swallows escapes and zero bytes, marks attributes and
// turns each accepted byte into at most one emitter job.
// ----------------------------------------------------------------------------
module aae_dec
    import aae_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_first,
    output t_job       o_job
);

    logic r_esc;
    logic r_halt;
    logic n_esc;
    logic n_halt;
    logic esc_eff;
    logic halt_eff;

    // a new call clears both flags before the byte is looked at
    assign esc_eff  = i_first ? 1'b0 : r_esc;
    assign halt_eff = i_first ? 1'b0 : r_halt;

    // classify the byte
    always_comb begin
        n_esc      = esc_eff;
        n_halt     = halt_eff;
        o_job.vld  = 1'b0;
        o_job.seq  = 1'b0;
        o_job.data = i_byte;
        priority if (halt_eff) begin
            // call ended, byte dropped
        end else if (esc_eff) begin
            n_esc     = 1'b0;
            o_job.vld = i_accept;
            o_job.seq = 1'b1;
        end else if (i_byte == ZERO_BYTE) begin
            n_halt = 1'b1;
        end else if (i_byte == ESC_CHAR) begin
            n_esc = 1'b1;
        end else begin
            o_job.vld = i_accept;
        end
    end

    // state update on each transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc  <= 1'b0;
            r_halt <= 1'b0;
        end else if (i_accept) begin
            r_esc  <= n_esc;
            r_halt <= n_halt;
        end
    end

endmodule

// ===== design/aae_emit.sv =====
// ----------------------------------------------------------------------------
// aae_emit
// Job register plus output register: passes plain bytes straight on and
// steps through the escape sequence of an attribute one character a cycle when not stalled.
// ----------------------------------------------------------------------------
module aae_emit
    import aae_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_out_ready,
    output logic       o_job_ready,
    output logic       o_out_valid,
    output logic [7:0] o_out_char,
    output logic       o_out_last
);

    logic                 r_job_vld;
    logic                 r_job_seq;
    logic [7:0]           r_job_data;
    logic [SEQ_IDX_W-1:0] r_idx;
    logic                 r_out_vld;
    logic [7:0]           r_out_char;
    logic                 r_out_last;
    t_seq_char            seq_c;
    logic [7:0]           cur_char;
    logic                 cur_last;
    logic                 load;
    logic                 take;
    logic                 done;

    // character of the job at the current position
    assign seq_c    = seq_char(r_job_data, r_idx);
    assign cur_char = r_job_seq ? seq_c.ch : r_job_data;
    assign cur_last = r_job_seq ? seq_c.last : 1'b1;

    // output register frees up when empty or taken
    assign load        = !r_out_vld || i_out_ready;
    assign take        = r_job_vld && load;
    assign done        = take && cur_last;
    assign o_job_ready = !r_job_vld || done;

    // job register and sequence position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_job.vld) begin
                r_job_vld <= 1'b1;
            end else if (done) begin
                r_job_vld <= 1'b0;
            end
            if (done) begin
                r_idx <= '0;
            end else if (take) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.vld) begin
            r_job_seq  <= i_job.seq;
            r_job_data <= i_job.data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load) begin
            r_out_vld <= r_job_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_char <= cur_char;
            r_out_last <= cur_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

// ===== design/aae_chk.sv =====
// ----------------------------------------------------------------------------
// aae_chk
// Port-level checks for the color attribute expander, bound to the top.
// ----------------------------------------------------------------------------
module aae_chk
    import aae_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last
);

    // a stalled transaction keeps its character
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_out_last))
        else $error("output changed while stalled");

    // nothing is offered right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // an escape character only ever opens a sequence
    a_esc_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_char == ESC_CHAR |-> !i_out_last)
        else $error("escape character ends a run");

    // mid-run characters belong to the sequence alphabet
    a_mid_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> i_out_char == ESC_CHAR
            || i_out_char == CH_LBRACK || i_out_char == CH_SEMI
            || (i_out_char >= CH_DIGIT0 && i_out_char <= CH_DIGIT9))
        else $error("unexpected character inside a sequence");

endmodule

bind color_attribute_to_ansi_escape_core aae_chk u_aae_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.char_out),
    .i_out_last  (o_out.last_of_run)
);
